>>> hw/rtl/bpfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfm_pkg
// Shared types, codes and defaults for the buffer pool frame manager.
// ----------------------------------------------------------------------------
package bpfm_pkg;

  localparam int unsigned POOL_FRAMES_DEF = 16;
  localparam logic [15:0] PIN_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    FUNC_FETCH  = 3'd0,
    FUNC_UNPIN  = 3'd1,
    FUNC_NEW    = 3'd2,
    FUNC_FLUSH  = 3'd3,
    FUNC_DELETE = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_RES   = 3'd1,
    STS_NO_FRAME  = 3'd2,
    STS_PINNED    = 3'd3,
    STS_NOT_PINNED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EXEC,
    ST_DONE
  } ctl_state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] page_id;
    logic        mark_dirty;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame_index;
    logic        writeback_valid;
    logic [31:0] writeback_page;
    logic        read_valid;
    logic [31:0] assigned_page;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic exec;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/bpfm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/bpfm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfm_ctrl
// Request sequencer: table scan, execute, result hand-off.
// ----------------------------------------------------------------------------
module bpfm_ctrl
  import bpfm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:  if (sts_i.scan_last) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_DONE;
      ST_DONE:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cmd_o.start = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.issue = (state_q == ST_SCAN);
    cmd_o.exec  = (state_q == ST_EXEC);
    cmd_o.load  = (state_q == ST_DONE) && sts_i.out_free;
  end

endmodule

>>> hw/rtl/bpfm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfm_datapath
// Frame table, free FIFO, LRU ranks, page counter and result register.
// ----------------------------------------------------------------------------
module bpfm_datapath
  import bpfm_pkg::*;
#(
  parameter int unsigned POOL_FRAMES = POOL_FRAMES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  req_t        req_i,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output rsp_t        rsp_o
);

  localparam int unsigned FW = $clog2(POOL_FRAMES);
  localparam int unsigned CW = FW + 1;
  localparam int unsigned WW = 32 + 16 + 1 + FW;
  localparam logic [FW-1:0] LastIdx = FW'(POOL_FRAMES - 1);
  localparam logic [CW-1:0] NumFrames = CW'(POOL_FRAMES);

  // request and scan
  req_t             req_q;
  logic [FW-1:0]    idx_q;
  logic             p_valid_q;
  logic [FW-1:0]    p_idx_q;

  // per-frame flags and LRU bookkeeping
  logic [POOL_FRAMES-1:0] valid_q, lru_q;
  logic [CW-1:0]    lru_cnt_q;
  logic             pend_v_q;
  logic [FW-1:0]    pend_k_q;

  // scan captures
  logic             hit_v_q, np_v_q;
  logic [FW-1:0]    hit_idx_q, np_idx_q, vic_idx_q;
  logic [15:0]      hit_pin_q;
  logic             hit_dirty_q, vic_dirty_q;
  logic [FW-1:0]    hit_rank_q;
  logic [31:0]      vic_page_q;

  // free FIFO
  logic [FW-1:0]    fq_head_q;
  logic [CW-1:0]    fq_cnt_q, fq_fill_q;
  logic [FW-1:0]    fq_rdata, fq_head_val, fq_tail, fq_head_inc;
  logic [CW-1:0]    fq_sum;

  logic [31:0]      next_page_q;
  logic             out_valid_q;
  rsp_t             rsp_q, res_d, res_q;

  // frame RAM
  logic [WW-1:0]    fr_rdata, fr_wdata;
  logic             fr_we;
  logic [FW-1:0]    fr_waddr;
  logic [31:0]      rd_page;
  logic [15:0]      rd_pin;
  logic             rd_dirty;
  logic [FW-1:0]    rd_rank, adj_rank;
  logic             shift_rank, wb_need, pmatch, npmatch, pvic;

  // execute
  logic             have_free, have_lru, take_ok, take_use;
  logic [FW-1:0]    take_f;
  logic             ex_we;
  logic [FW-1:0]    ex_addr;
  logic [31:0]      ex_page;
  logic [15:0]      ex_pin;
  logic             ex_dirty;
  logic [FW-1:0]    ex_rank;
  logic             set_v, clr_v, clr_np, lru_set, lru_clr, lru_inc, lru_dec;
  logic [FW-1:0]    set_i, clr_i, lru_set_i, lru_clr_i;
  logic             pend_new_v;
  logic [FW-1:0]    pend_new_k;
  logic             fq_pop, fq_push, np_inc;
  logic [POOL_FRAMES-1:0] valid_d, lru_d;

  bpfm_ram #(.WIDTH(WW), .DEPTH(POOL_FRAMES)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (idx_q),
    .rdata_o (fr_rdata)
  );

  bpfm_ram #(.WIDTH(FW), .DEPTH(POOL_FRAMES)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fq_push),
    .waddr_i (fq_tail),
    .wdata_i (hit_idx_q),
    .raddr_i (fq_head_q),
    .rdata_o (fq_rdata)
  );

  // scan stage
  assign rd_page    = fr_rdata[WW-1:FW+17];
  assign rd_pin     = fr_rdata[FW+16:FW+1];
  assign rd_dirty   = fr_rdata[FW];
  assign rd_rank    = fr_rdata[FW-1:0];
  assign shift_rank = pend_v_q && lru_q[p_idx_q] && (rd_rank > pend_k_q);
  assign adj_rank   = shift_rank ? rd_rank - FW'(1) : rd_rank;
  assign wb_need    = p_valid_q && shift_rank;
  assign pmatch     = p_valid_q && valid_q[p_idx_q] && (rd_page == req_q.page_id);
  assign npmatch    = p_valid_q && valid_q[p_idx_q] && (rd_page == next_page_q);
  assign pvic       = p_valid_q && lru_q[p_idx_q] && (adj_rank == '0);

  assign sts_o.scan_last = (idx_q == LastIdx);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // free FIFO addressing; slots not yet written still hold their own index
  assign fq_head_val = (CW'(fq_head_q) < fq_fill_q) ? fq_rdata : fq_head_q;
  assign fq_sum      = CW'(fq_head_q) + fq_cnt_q;
  assign fq_tail     = (fq_sum >= NumFrames) ? FW'(fq_sum - NumFrames) : FW'(fq_sum);
  assign fq_head_inc = (fq_head_q == LastIdx) ? '0 : fq_head_q + FW'(1);

  assign have_free = (fq_cnt_q != '0);
  assign have_lru  = (lru_cnt_q != '0);
  assign take_ok   = have_free || have_lru;
  assign take_f    = have_free ? fq_head_val : vic_idx_q;

  always_comb begin
    res_d      = '0;
    take_use   = 1'b0;
    ex_we      = 1'b0;
    ex_addr    = hit_idx_q;
    ex_page    = req_q.page_id;
    ex_pin     = hit_pin_q;
    ex_dirty   = hit_dirty_q;
    ex_rank    = hit_rank_q;
    set_v      = 1'b0;
    set_i      = take_f;
    clr_v      = 1'b0;
    clr_i      = hit_idx_q;
    clr_np     = 1'b0;
    lru_set    = 1'b0;
    lru_set_i  = hit_idx_q;
    lru_clr    = 1'b0;
    lru_clr_i  = hit_idx_q;
    lru_inc    = 1'b0;
    lru_dec    = 1'b0;
    pend_new_v = 1'b0;
    pend_new_k = hit_rank_q;
    fq_pop     = 1'b0;
    fq_push    = 1'b0;
    np_inc     = 1'b0;

    unique case (req_q.func)
      FUNC_FETCH: begin
        if (hit_v_q) begin
          ex_we = 1'b1;
          if (hit_pin_q != PIN_MAX) ex_pin = hit_pin_q + 16'd1;
          if (lru_q[hit_idx_q]) begin
            lru_clr    = 1'b1;
            lru_dec    = 1'b1;
            pend_new_v = 1'b1;
          end
          res_d.frame_index = 4'(hit_idx_q);
        end else begin
          take_use = 1'b1;
          if (!take_ok) begin
            res_d.status = STS_NO_FRAME;
          end else begin
            ex_we    = 1'b1;
            ex_addr  = take_f;
            ex_pin   = 16'd1;
            ex_dirty = 1'b0;
            ex_rank  = '0;
            set_v    = 1'b1;
            res_d.read_valid  = 1'b1;
            res_d.frame_index = 4'(take_f);
          end
        end
      end
      FUNC_UNPIN: begin
        if (!hit_v_q) begin
          res_d.status = STS_NOT_RES;
        end else begin
          ex_we    = 1'b1;
          ex_dirty = hit_dirty_q | req_q.mark_dirty;
          if (hit_pin_q == '0) begin
            res_d.status = STS_NOT_PINNED;
          end else begin
            ex_pin = hit_pin_q - 16'd1;
            if ((hit_pin_q == 16'd1) && !lru_q[hit_idx_q]) begin
              lru_set = 1'b1;
              lru_inc = 1'b1;
              ex_rank = FW'(lru_cnt_q);
            end
          end
        end
      end
      FUNC_NEW: begin
        take_use = 1'b1;
        if (!take_ok) begin
          res_d.status = STS_NO_FRAME;
        end else begin
          np_inc   = 1'b1;
          clr_np   = np_v_q;
          ex_we    = 1'b1;
          ex_addr  = take_f;
          ex_page  = next_page_q;
          ex_pin   = 16'd1;
          ex_dirty = 1'b0;
          ex_rank  = '0;
          set_v    = 1'b1;
          res_d.frame_index   = 4'(take_f);
          res_d.assigned_page = next_page_q;
        end
      end
      FUNC_FLUSH: begin
        if (!hit_v_q) begin
          res_d.status = STS_NOT_RES;
        end else begin
          ex_we    = 1'b1;
          ex_dirty = 1'b0;
          res_d.writeback_valid = 1'b1;
          res_d.writeback_page  = req_q.page_id;
        end
      end
      FUNC_DELETE: begin
        if (hit_v_q) begin
          if (hit_pin_q != '0) begin
            res_d.status = STS_PINNED;
          end else begin
            ex_we    = 1'b1;
            ex_dirty = 1'b0;
            ex_pin   = '0;
            clr_v    = 1'b1;
            if (lru_q[hit_idx_q]) begin
              lru_clr    = 1'b1;
              lru_dec    = 1'b1;
              pend_new_v = 1'b1;
            end
            fq_push = cmd_i.exec && (fq_cnt_q < NumFrames);
          end
        end
      end
      default: begin
        res_d.status = STS_OK;
      end
    endcase

    if (take_use && take_ok) begin
      if (have_free) begin
        fq_pop = 1'b1;
      end else begin
        lru_clr    = 1'b1;
        lru_clr_i  = vic_idx_q;
        lru_dec    = 1'b1;
        pend_new_v = 1'b1;
        pend_new_k = '0;
        if (vic_dirty_q) begin
          res_d.writeback_valid = 1'b1;
          res_d.writeback_page  = vic_page_q;
        end
      end
    end

    valid_d = valid_q;
    if (clr_np) valid_d[np_idx_q] = 1'b0;
    if (clr_v)  valid_d[clr_i] = 1'b0;
    if (set_v)  valid_d[set_i] = 1'b1;
    lru_d = lru_q;
    if (lru_clr) lru_d[lru_clr_i] = 1'b0;
    if (lru_set) lru_d[lru_set_i] = 1'b1;
  end

  // frame RAM write port: execute update, else rank shift from the scan
  always_comb begin
    if (cmd_i.exec) begin
      fr_we    = ex_we;
      fr_waddr = ex_addr;
      fr_wdata = {ex_page, ex_pin, ex_dirty, ex_rank};
    end else begin
      fr_we    = wb_need;
      fr_waddr = p_idx_q;
      fr_wdata = {rd_page, rd_pin, rd_dirty, adj_rank};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      p_valid_q   <= 1'b0;
      valid_q     <= '0;
      lru_q       <= '0;
      lru_cnt_q   <= '0;
      pend_v_q    <= 1'b0;
      pend_k_q    <= '0;
      hit_v_q     <= 1'b0;
      np_v_q      <= 1'b0;
      fq_head_q   <= '0;
      fq_cnt_q    <= NumFrames;
      fq_fill_q   <= '0;
      next_page_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      p_valid_q <= cmd_i.issue;
      if (cmd_i.start) begin
        idx_q   <= '0;
        hit_v_q <= 1'b0;
        np_v_q  <= 1'b0;
      end else begin
        if (cmd_i.issue) idx_q <= idx_q + FW'(1);
        if (pmatch) hit_v_q <= 1'b1;
        if (npmatch) np_v_q <= 1'b1;
      end
      if (cfg_valid_i) next_page_q <= cfg_data_i;
      if (cmd_i.exec) begin
        valid_q  <= valid_d;
        lru_q    <= lru_d;
        pend_v_q <= pend_new_v;
        pend_k_q <= pend_new_k;
        if (lru_inc) lru_cnt_q <= lru_cnt_q + CW'(1);
        if (lru_dec) lru_cnt_q <= lru_cnt_q - CW'(1);
        if (np_inc) next_page_q <= next_page_q + 32'd1;
        if (fq_pop) begin
          fq_head_q <= fq_head_inc;
          fq_cnt_q  <= fq_cnt_q - CW'(1);
        end
        if (fq_push) begin
          fq_cnt_q <= fq_cnt_q + CW'(1);
          if (fq_fill_q < NumFrames) fq_fill_q <= fq_fill_q + CW'(1);
        end
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) req_q <= req_i;
    p_idx_q <= idx_q;
    if (pmatch && !hit_v_q) begin
      hit_idx_q   <= p_idx_q;
      hit_pin_q   <= rd_pin;
      hit_dirty_q <= rd_dirty;
      hit_rank_q  <= adj_rank;
    end
    if (npmatch) np_idx_q <= p_idx_q;
    if (pvic) begin
      vic_idx_q   <= p_idx_q;
      vic_dirty_q <= rd_dirty;
      vic_page_q  <= rd_page;
    end
    if (cmd_i.exec) res_q <= res_d;
    if (cmd_i.load) rsp_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

endmodule

>>> hw/rtl/buffer_pool_frame_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager_top
// Page frame pool manager with least-recently-unpinned replacement.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o, in_req_i): one request per transfer,
//     fetch, unpin, new page, flush or delete.
//   out channel (out_valid_o/out_ready_i, out_rsp_o): one response per
//     request, in order: status, frame, write-back and read-in requests.
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_data_i): loads the first page
//     id for new-page requests; always ready, write only while idle.
// Timing: each request scans the frame table one entry per cycle, then
//   executes and loads the response register; a new request is accepted only
//   after the previous response has been loaded into the output register.
// Reset: all frames free in index order, LRU list empty, next page id 0.
// Backpressure: a finished response waits in the result register until the
//   output register is free; no new request is accepted meanwhile, since
//   the input is ready only while the sequencer is idle.
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager_top
  import bpfm_pkg::*;
#(
  parameter int unsigned POOL_FRAMES = POOL_FRAMES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  bpfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpfm_datapath #(.POOL_FRAMES(POOL_FRAMES)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .rsp_o       (out_rsp_o)
  );

endmodule
